>>> hdl/apt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types, widths and register indexes of the affine point transform.
// ----------------------------------------------------------------------------
package apt_pkg;

    // Fixed-point format of coordinates and matrix elements
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Fixed widths of the 32-bit field slots
    localparam int SLOT_W = 32;
    localparam int REG_W  = 64;

    // Arithmetic widths
    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = SUM_W - FRAC_BITS;

    // Matrix geometry: three rows of four columns, two elements per register
    localparam int NUM_ROWS  = 3;
    localparam int NUM_COLS  = 4;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;

    // Pipeline depth: multiply, pair add, final add, shift and saturate
    localparam int NUM_STAGES = 4;

    typedef logic signed [SLOT_W-1:0]      t_slot;
    typedef logic        [REG_W-1:0]       t_reg;
    typedef logic        [CFG_IDX_W-1:0]   t_cfg_idx;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic signed [SH_W-1:0]        t_shift;

    // Register indexes
    localparam t_cfg_idx REG_ROW0_C01 = 3'd0;
    localparam t_cfg_idx REG_ROW0_C23 = 3'd1;
    localparam t_cfg_idx REG_ROW1_C01 = 3'd2;
    localparam t_cfg_idx REG_ROW1_C23 = 3'd3;
    localparam t_cfg_idx REG_ROW2_C01 = 3'd4;
    localparam t_cfg_idx REG_ROW2_C23 = 3'd5;

    // Fixed-point one, placed in the low element of a register
    localparam t_reg ONE_LO = t_reg'(64'd1 << FRAC_BITS);
    localparam t_reg ONE_HI = t_reg'(ONE_LO << SLOT_W);

    // Saturation rails, sign extended into a 32-bit slot
    localparam t_slot SAT_MAX = t_slot'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam t_slot SAT_MIN = t_slot'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    // Low COORD_WIDTH bits of a slot, as a signed coordinate
    function automatic t_coord f_coord(input logic [SLOT_W-1:0] v);
        return t_coord'(v[COORD_WIDTH-1:0]);
    endfunction

endpackage

>>> hdl/apt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_if
// Handshake channels of the affine point transform: point in, point out and
// configuration write.
// ----------------------------------------------------------------------------
interface apt_pt_in_if;
    import apt_pkg::*;

    logic  valid;
    logic  ready;
    t_slot in_x;
    t_slot in_y;
    t_slot in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface apt_pt_out_if;
    import apt_pkg::*;

    logic  valid;
    logic  ready;
    t_slot out_x;
    t_slot out_y;
    t_slot out_z;
    logic  saturated;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input saturated, output ready);
endinterface

interface apt_cfg_if;
    import apt_pkg::*;

    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_reg     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/affine_point_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_transform_unit
// Transforms 3D Q16.16 points by the upper three rows of a 4x4 matrix with an
// implied w of one; results are truncated and saturated to the coordinate
// range, with a flag when any coordinate clips.
// ----------------------------------------------------------------------------
// Results pass the product, pair-sum, dot-product and output registers.
// Throughput: one point per cycle; the pipeline advances whenever the output
//   register is empty or being taken, so it holds only under output stall.
// Reset: synchronous, active low; clears stage valid bits and loads the
//   identity matrix. Configuration writes are always accepted.
module affine_point_transform_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apt_pt_in_if.sink     i_pt,
    apt_pt_out_if.source  o_pt,
    apt_cfg_if.sink       i_cfg
);
    import apt_pkg::*;

    // Matrix registers
    t_reg r_mat [NUM_REGS];

    // Pipeline control
    logic [NUM_STAGES-1:0] r_vld;
    logic                  adv;

    // Stage 1: products and translation terms
    t_coord c_elem [NUM_ROWS][NUM_COLS];
    t_coord c_pt   [NUM_COLS-1];
    t_prod  r_p    [NUM_ROWS][NUM_COLS-1];
    t_sum   r_t    [NUM_ROWS];

    // Stage 2 and 3: adder tree
    t_sum   r_a    [NUM_ROWS];
    t_sum   r_b    [NUM_ROWS];
    t_sum   r_s    [NUM_ROWS];

    // Stage 4: shift and saturate
    t_shift c_sh   [NUM_ROWS];
    t_slot  n_out  [NUM_ROWS];
    logic   [NUM_ROWS-1:0] c_clip;
    t_slot  r_out  [NUM_ROWS];
    logic   r_sat;

    // Configuration writes; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[REG_ROW0_C01] <= ONE_LO;
            r_mat[REG_ROW0_C23] <= '0;
            r_mat[REG_ROW1_C01] <= ONE_HI;
            r_mat[REG_ROW1_C23] <= '0;
            r_mat[REG_ROW2_C01] <= '0;
            r_mat[REG_ROW2_C23] <= ONE_LO;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ROW0_C01: r_mat[REG_ROW0_C01] <= i_cfg.data;
                REG_ROW0_C23: r_mat[REG_ROW0_C23] <= i_cfg.data;
                REG_ROW1_C01: r_mat[REG_ROW1_C01] <= i_cfg.data;
                REG_ROW1_C23: r_mat[REG_ROW1_C23] <= i_cfg.data;
                REG_ROW2_C01: r_mat[REG_ROW2_C01] <= i_cfg.data;
                REG_ROW2_C23: r_mat[REG_ROW2_C23] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Whole pipeline moves together unless the output is held
    assign adv        = !r_vld[NUM_STAGES-1] || o_pt.ready;
    assign i_pt.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_pt.valid};
        end
    end

    // Element and coordinate unpacking
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                c_elem[r][c] = (c % 2 == 1) ?
                    f_coord(r_mat[r * 2 + c / 2][REG_W-1:SLOT_W]) :
                    f_coord(r_mat[r * 2 + c / 2][SLOT_W-1:0]);
            end
        end
        c_pt[0] = f_coord(i_pt.in_x);
        c_pt[1] = f_coord(i_pt.in_y);
        c_pt[2] = f_coord(i_pt.in_z);
    end

    // Stage 1: one multiplier per linear element; translation is a shift
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_COLS - 1; c++) begin
                    r_p[r][c] <= t_prod'(c_elem[r][c]) * t_prod'(c_pt[c]);
                end
                r_t[r] <= t_sum'(c_elem[r][NUM_COLS-1]) <<< FRAC_BITS;
            end
        end
    end

    // Stage 2: pair sums
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_a[r] <= t_sum'(r_p[r][0]) + t_sum'(r_p[r][1]);
                r_b[r] <= t_sum'(r_p[r][2]) + r_t[r];
            end
        end
    end

    // Stage 3: full-width dot product
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_s[r] <= r_a[r] + r_b[r];
            end
        end
    end

    // Stage 4: truncate the fraction, clip to the coordinate range
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            c_sh[r]   = t_shift'(r_s[r] >>> FRAC_BITS);
            c_clip[r] = (c_sh[r][SH_W-1:COORD_WIDTH-1] != '0) &&
                        (c_sh[r][SH_W-1:COORD_WIDTH-1] != '1);
            if (c_clip[r]) begin
                n_out[r] = c_sh[r][SH_W-1] ? SAT_MIN : SAT_MAX;
            end else begin
                n_out[r] = t_slot'(t_coord'(c_sh[r][COORD_WIDTH-1:0]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_out[r] <= n_out[r];
            end
            r_sat <= |c_clip;
        end
    end

    assign o_pt.valid     = r_vld[NUM_STAGES-1];
    assign o_pt.out_x     = r_out[0];
    assign o_pt.out_y     = r_out[1];
    assign o_pt.out_z     = r_out[2];
    assign o_pt.saturated = r_sat;

    // An accepted point enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> r_vld[0])
        else $error("accepted point missing from first stage");

    // Output stall freezes every stage
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_STAGES-1] && !o_pt.ready) |=> $stable(r_vld))
        else $error("pipeline moved under output stall");

    // A flagged result has at least one coordinate on a rail
    a_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt.valid && o_pt.saturated) |->
            (o_pt.out_x == SAT_MAX || o_pt.out_x == SAT_MIN ||
             o_pt.out_y == SAT_MAX || o_pt.out_y == SAT_MIN ||
             o_pt.out_z == SAT_MAX || o_pt.out_z == SAT_MIN))
        else $error("saturation flag without a clipped coordinate");

endmodule

>>> test/apt_transform_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_transform_checker
// Watches the point, result and configuration channels of the affine point
// transform. It keeps its own copy of the matrix registers and computes the
// transformed point for every accepted input point. Each accepted result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module apt_transform_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // point input channel
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  apt_pkg::t_slot    i_in_x,
    input  apt_pkg::t_slot    i_in_y,
    input  apt_pkg::t_slot    i_in_z,
    // result channel
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  apt_pkg::t_slot    i_out_x,
    input  apt_pkg::t_slot    i_out_y,
    input  apt_pkg::t_slot    i_out_z,
    input  logic              i_out_sat,
    // configuration write channel
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  apt_pkg::t_cfg_idx i_cfg_index,
    input  apt_pkg::t_reg     i_cfg_data,
    // to the testbench top
    output int                o_fail_count,
    output int                o_pending
);
    import apt_pkg::*;

    // Fixed-point one in the low element of a register
    localparam t_reg FX_ONE_LO = t_reg'(1) << FRAC_BITS;

    typedef struct packed {
        t_slot x;
        t_slot y;
        t_slot z;
        logic  sat;
    } t_xformed;

    t_reg     matrix_regs [NUM_REGS];
    t_xformed xformed_q [$];
    int       mismatches = 0;

    // Low COORD_WIDTH bits of a slot, sign extended to 64 bits
    function automatic logic signed [63:0] widen_coord(input t_slot v);
        logic signed [63:0] w;
        w = 64'(v) << (64 - COORD_WIDTH);
        return w >>> (64 - COORD_WIDTH);
    endfunction

    // One output coordinate: row . (x, y, z, 1), truncated and clipped
    function automatic void dot_row(input int row, input logic signed [63:0] x,
                                    input logic signed [63:0] y,
                                    input logic signed [63:0] z,
                                    output t_slot v, inout logic clip);
        logic signed [63:0]  e [NUM_COLS];
        logic signed [127:0] acc;
        logic signed [127:0] hi_rail;
        logic signed [127:0] lo_rail;
        t_reg                w;
        for (int c = 0; c < NUM_COLS; c++) begin
            w    = matrix_regs[row * 2 + c / 2];
            e[c] = widen_coord((c % 2) ? w[63:32] : w[31:0]);
        end
        // exact sum at 128 bits, then floor shift
        acc     = e[0] * x + e[1] * y + e[2] * z + (e[3] <<< FRAC_BITS);
        acc     = acc >>> FRAC_BITS;
        hi_rail = (128'sd1 <<< (COORD_WIDTH - 1)) - 128'sd1;
        lo_rail = -hi_rail - 128'sd1;
        if (acc > hi_rail) begin
            v    = t_slot'(hi_rail);
            clip = 1'b1;
        end else if (acc < lo_rail) begin
            v    = t_slot'(lo_rail);
            clip = 1'b1;
        end else begin
            v = t_slot'(acc);
        end
    endfunction

    function automatic t_xformed transform_point(input t_slot px, input t_slot py,
                                                 input t_slot pz);
        t_xformed           res;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        t_slot              vx;
        t_slot              vy;
        t_slot              vz;
        logic               clip;
        x    = widen_coord(px);
        y    = widen_coord(py);
        z    = widen_coord(pz);
        clip = 1'b0;
        dot_row(0, x, y, z, vx, clip);
        dot_row(1, x, y, z, vy, clip);
        dot_row(2, x, y, z, vz, clip);
        res.x   = vx;
        res.y   = vy;
        res.z   = vz;
        res.sat = clip;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Track configuration, predict on input, compare on output
    always @(posedge i_clk) begin
        t_xformed want;
        if (!i_rst_n) begin
            foreach (matrix_regs[i]) matrix_regs[i] = '0;
            matrix_regs[REG_ROW0_C01] = FX_ONE_LO;
            matrix_regs[REG_ROW1_C01] = FX_ONE_LO << SLOT_W;
            matrix_regs[REG_ROW2_C23] = FX_ONE_LO;
            xformed_q.delete();
        end else begin
            // writes to unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_REGS)
                matrix_regs[i_cfg_index] = i_cfg_data;
            if (i_in_valid && i_in_ready)
                xformed_q.push_back(transform_point(i_in_x, i_in_y, i_in_z));
            if (i_out_valid && i_out_ready) begin
                if (xformed_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %h %h %h %b",
                             $time, i_out_x, i_out_y, i_out_z, i_out_sat);
                end else begin
                    want = xformed_q.pop_front();
                    check_field("out_x", want.x, i_out_x);
                    check_field("out_y", want.y, i_out_y);
                    check_field("out_z", want.z, i_out_z);
                    check_field("saturated", 32'(want.sat), 32'(i_out_sat));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= xformed_q.size();
    end

endmodule

>>> test/tb_affine_point_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_affine_point_transform_unit
// Drives points and matrix settings into the affine point transform: a short
// directed set (identity, rail coordinates, translation overflow both ways,
// ignored register indexes, all-max and all-min matrices), then random phases
// with fresh matrices, random idle on both channels, a quiet phase and a long
// output stall. Checking is done by apt_transform_checker.
// ----------------------------------------------------------------------------
module tb_affine_point_transform_unit;
    import apt_pkg::*;

    localparam int       CLK_PERIOD    = 20;
    localparam int       RESET_CYCLES  = 9;
    localparam int       CYCLE_LIMIT   = 200_000;
    localparam int       HOLD_CYCLES   = 80;
    localparam int       NUM_PHASES    = 10;
    localparam int       PHASE_POINTS  = 65;
    localparam int       QUIET_PHASE   = 8;
    localparam int       HOLD_PHASE    = 1;
    localparam int       IDLE_PCT      = 24;
    localparam t_cfg_idx REG_UNUSED_6  = 3'd6;
    localparam t_cfg_idx REG_UNUSED_7  = 3'd7;
    localparam t_slot    COORD_MAX     = 32'h7FFF_FFFF;
    localparam t_slot    COORD_MIN     = 32'h8000_0000;
    localparam int       FX_ONE        = 1 << FRAC_BITS;
    localparam int       SMALL_ELEM    = 4 << FRAC_BITS;
    localparam int       SMALL_COORD   = 1024 << FRAC_BITS;

    // How matrix elements are drawn for a phase
    typedef enum int {
        MIX_SMALL, MIX_FULL, MIX_EXTREME, MIX_ANY, MIX_ALL_MAX, MIX_ALL_MIN, MIX_ZERO
    } t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   hold_requests = 0;
    bit   in_idle_on = 1'b1;
    bit   out_idle_on = 1'b1;

    t_mix phase_mix [NUM_PHASES] = '{MIX_SMALL, MIX_ANY, MIX_SMALL, MIX_FULL, MIX_EXTREME,
                                     MIX_ALL_MAX, MIX_ZERO, MIX_ALL_MIN, MIX_SMALL, MIX_ANY};

    apt_pt_in_if  pt_in ();
    apt_pt_out_if pt_out ();
    apt_cfg_if    cfg ();

    affine_point_transform_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_in),
        .o_pt    (pt_out),
        .i_cfg   (cfg)
    );

    apt_transform_checker xform_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (pt_in.valid),
        .i_in_ready   (pt_in.ready),
        .i_in_x       (pt_in.in_x),
        .i_in_y       (pt_in.in_y),
        .i_in_z       (pt_in.in_z),
        .i_out_valid  (pt_out.valid),
        .i_out_ready  (pt_out.ready),
        .i_out_x      (pt_out.out_x),
        .i_out_y      (pt_out.out_y),
        .i_out_z      (pt_out.out_z),
        .i_out_sat    (pt_out.saturated),
        .i_cfg_valid  (cfg.valid),
        .i_cfg_ready  (cfg.ready),
        .i_cfg_index  (cfg.index),
        .i_cfg_data   (cfg.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stall, plus a long hold-off on request
    initial begin
        int hold_served;
        hold_served = 0;
        pt_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                pt_out.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
            end
            pt_out.ready <= !(out_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic t_slot rand_elem(input t_mix mix);
        t_mix pick;
        pick = mix;
        if (mix == MIX_ANY) pick = t_mix'($urandom_range(int'(MIX_EXTREME)));
        case (pick)
            MIX_SMALL:   return t_slot'(int'($urandom_range(2 * SMALL_ELEM)) - SMALL_ELEM);
            MIX_FULL:    return t_slot'($urandom);
            MIX_ALL_MAX: return COORD_MAX;
            MIX_ALL_MIN: return COORD_MIN;
            MIX_ZERO:    return '0;
            default: begin
                case ($urandom_range(4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return t_slot'(FX_ONE);
                    3:       return t_slot'(-FX_ONE);
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // Mostly moderate coordinates so sums stay in range, some full-range and rails
    function automatic t_slot rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 55) return t_slot'(int'($urandom_range(2 * SMALL_COORD)) - SMALL_COORD);
        if (r < 85) return t_slot'($urandom);
        case ($urandom_range(5))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return t_slot'(-1);
            3:       return t_slot'(1);
            4:       return t_slot'(FX_ONE);
            default: return '0;
        endcase
    endfunction

    // One point transaction; valid stays up for the next call
    task automatic send_point(input t_slot x, input t_slot y, input t_slot z);
        while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
            pt_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_in.valid <= 1'b1;
        pt_in.in_x  <= x;
        pt_in.in_y  <= y;
        pt_in.in_z  <= z;
        do @(posedge i_clk); while (!pt_in.ready);
    endtask

    // Stop offering points and wait until every result is back
    task automatic settle();
        pt_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One register transaction; cfg_idle drops valid after the last one
    task automatic write_reg(input t_cfg_idx idx, input t_reg value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
    endtask

    task automatic cfg_idle();
        cfg.valid <= 1'b0;
    endtask

    task automatic load_matrix(input t_mix mix);
        for (t_cfg_idx r = REG_ROW0_C01; r <= REG_ROW2_C23; r++)
            write_reg(r, {rand_elem(mix), rand_elem(mix)});
    endtask

    // Stimulus
    initial begin
        i_rst_n     <= 1'b0;
        pt_in.valid <= 1'b0;
        pt_in.in_x  <= '0;
        pt_in.in_y  <= '0;
        pt_in.in_z  <= '0;
        cfg.valid   <= 1'b0;
        cfg.index   <= REG_ROW0_C01;
        cfg.data    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity after reset, rail coordinates
        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MIN, t_slot'(FX_ONE));
        send_point(COORD_MIN, COORD_MAX, t_slot'(-1));
        send_point(t_slot'(1), t_slot'(-1), t_slot'(FX_ONE + FX_ONE / 2));

        // rail translations: positive and negative overflow
        settle();
        write_reg(REG_ROW0_C23, {COORD_MAX, 32'h0});
        write_reg(REG_ROW1_C23, {COORD_MIN, 32'h0});
        write_reg(REG_ROW2_C23, {COORD_MAX, t_slot'(FX_ONE)});
        cfg_idle();
        send_point(COORD_MAX, COORD_MIN, '0);
        send_point('0, '0, '0);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN);
        send_point(t_slot'(-FX_ONE), t_slot'(FX_ONE), t_slot'(-1));

        // writes to unknown indexes leave the matrix alone
        settle();
        write_reg(REG_UNUSED_6, '1);
        write_reg(REG_UNUSED_7, {2{COORD_MIN}});
        cfg_idle();
        send_point(COORD_MAX, COORD_MIN, '0);
        send_point('0, '0, COORD_MAX);
        send_point(t_slot'(FX_ONE), t_slot'(FX_ONE), t_slot'(FX_ONE));

        // all-max matrix
        settle();
        load_matrix(MIX_ALL_MAX);
        cfg_idle();
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, '0, '0);
        send_point('0, '0, '0);
        send_point(t_slot'(-FX_ONE), '0, '0);

        // all-min matrix
        settle();
        load_matrix(MIX_ALL_MIN);
        cfg_idle();
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, '0, '0);
        send_point('0, '0, '0);
        send_point(t_slot'(1), t_slot'(-1), '0);

        // random phases, each with a fresh matrix
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            load_matrix(phase_mix[phase]);
            if ($urandom_range(1))
                write_reg($urandom_range(1) ? REG_UNUSED_6 : REG_UNUSED_7,
                          {$urandom, $urandom});
            cfg_idle();
            in_idle_on  = (phase != QUIET_PHASE);
            out_idle_on = (phase != QUIET_PHASE);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                // long output stall while points keep coming
                if (phase == HOLD_PHASE && n == 5) hold_requests++;
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;

        settle();
        repeat (NUM_STAGES * 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/apt_pkg.sv
hdl/apt_if.sv
hdl/affine_point_transform_unit.sv
test/apt_transform_checker.sv
test/tb_affine_point_transform_unit.sv
